@@ design/lzsd_pkg.sv @@
package lzsd_pkg;

   localparam int WIN_AW      = 12;
   localparam int WINDOW_SIZE = 1 << WIN_AW;

   localparam int CSR_IDX_W = 4;
   localparam int CSR_DW    = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_LOOKAHEAD = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_SKIP      = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT     = CSR_IDX_W'(3);

   localparam logic [11:0] LOOKAHEAD_DEFAULT = 12'd18;
   localparam logic [3:0]  THRESHOLD_DEFAULT = 4'd2;
   localparam logic [7:0]  SPACE_CHAR        = 8'h20;
   localparam logic [3:0]  FLAGS_PER_BYTE    = 4'd8;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_COPY,
      ST_LIT
   } lzsd_state_type;

   typedef struct packed {
      logic clear;
      logic in_open;
      logic rd_first;
      logic put_copy;
      logic put_lit;
   } lzsd_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic go_lit;
      logic go_match;
      logic put_fire;
      logic cnt_last;
   } lzsd_status_type;

   // initial write position: window size minus lookahead, zero lookahead means default
   function automatic logic [WIN_AW-1:0] start_position(input logic [11:0] la);
      logic [11:0] f;
      f = (la == 12'd0) ? LOOKAHEAD_DEFAULT : la;
      return WIN_AW'(~f + 12'd1);
   endfunction

endpackage

@@ design/lzsd_window_ram.sv @@
module lzsd_window_ram import lzsd_pkg::*; (
   input  logic              clock,
   input  logic              we,
   input  logic [WIN_AW-1:0] waddr,
   input  logic [7:0]        wdata,
   input  logic              re,
   input  logic [WIN_AW-1:0] raddr,
   output logic [7:0]        rdata
);

   logic [7:0] mem_ff [WINDOW_SIZE];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         // forward a byte written in the same cycle
         if (we && (waddr == raddr)) begin
            rdata_ff <= wdata;
         end else begin
            rdata_ff <= mem_ff[raddr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ design/lzsd_ctrl.sv @@
module lzsd_ctrl import lzsd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  lzsd_status_type status,
   output lzsd_cmd_type    cmd
);

   lzsd_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (status.go_lit) begin
               state_in = ST_LIT;
            end else if (status.go_match) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_COPY;
         end
         ST_COPY: begin
            if (status.put_fire && status.cnt_last) state_in = ST_IDLE;
         end
         ST_LIT: begin
            if (status.put_fire) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_CLEAR: cmd.clear    = 1'b1;
         ST_IDLE:  cmd.in_open  = 1'b1;
         ST_READ:  cmd.rd_first = 1'b1;
         ST_COPY:  cmd.put_copy = 1'b1;
         ST_LIT:   cmd.put_lit  = 1'b1;
         default:  cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/lzsd_datapath.sv @@
module lzsd_datapath import lzsd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  lzsd_cmd_type         cmd,
   output lzsd_status_type      status,
   input  logic                 req_valid,
   input  logic [7:0]           req_in_byte,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DW-1:0]    csr_data,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_last_of_run,
   output logic                 rsp_stream_done
);

   logic [WIN_AW-1:0] wp_ff, wp_in;
   logic [31:0]       skip_ff, skip_in;
   logic [31:0]       emit_ff, emit_in;
   logic [3:0]        thr_ff, thr_in;
   logic [7:0]        flag_bits_ff, flag_bits_in;
   logic [3:0]        flags_left_ff, flags_left_in;
   logic              phase_ff, phase_in;
   logic [7:0]        off_lo_ff, off_lo_in;
   logic [WIN_AW-1:0] src_ff, src_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [7:0]        lit_ff, lit_in;
   logic [WIN_AW-1:0] clr_ff, clr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_done_ff, rsp_done_in;

   logic              take, is_flag, is_lit, is_lo;
   logic              emits, out_free, put_fire, cnt_last, done_now;
   logic [3:0]        thr_eff;
   logic [7:0]        put_byte;
   logic              ram_we, ram_re;
   logic [WIN_AW-1:0] ram_waddr;
   logic [7:0]        ram_wdata, ram_rdata;

   lzsd_window_ram u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (src_ff),
      .rdata (ram_rdata)
   );

   // input decode; once the output limit is used up every byte is dropped
   assign take    = cmd.in_open && req_valid && (emit_ff != 32'd0);
   assign is_flag = !phase_ff && (flags_left_ff == 4'd0);
   assign is_lit  = !phase_ff && (flags_left_ff != 4'd0) && flag_bits_ff[0];
   assign is_lo   = !phase_ff && (flags_left_ff != 4'd0) && !flag_bits_ff[0];
   assign thr_eff = (thr_ff == 4'd0) ? THRESHOLD_DEFAULT : thr_ff;

   assign emits    = (skip_ff == 32'd0) && (emit_ff != 32'd0);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign put_fire = (cmd.put_lit || cmd.put_copy) && (!emits || out_free);
   assign put_byte = cmd.put_lit ? lit_ff : ram_rdata;
   assign cnt_last = (cnt_ff == 5'd1);
   // emitting bytes and emit budget fall together, so this holds for the whole item
   assign done_now = (emit_ff[31:5] == 27'd0) && (emit_ff[4:0] <= cnt_ff);

   assign ram_we    = cmd.clear || put_fire;
   assign ram_waddr = cmd.clear ? clr_ff : wp_ff;
   assign ram_wdata = cmd.clear ? SPACE_CHAR : put_byte;
   assign ram_re    = cmd.rd_first || (put_fire && cmd.put_copy && !cnt_last);

   always_comb begin
      wp_in         = wp_ff;
      skip_in       = skip_ff;
      emit_in       = emit_ff;
      thr_in        = thr_ff;
      flag_bits_in  = flag_bits_ff;
      flags_left_in = flags_left_ff;
      phase_in      = phase_ff;
      off_lo_in     = off_lo_ff;
      src_in        = src_ff;
      cnt_in        = cnt_ff;
      lit_in        = lit_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_done_in   = rsp_done_ff;

      if (cmd.clear) begin
         clr_in = clr_ff + WIN_AW'(1);
      end

      if (take) begin
         priority if (is_flag) begin
            flag_bits_in  = req_in_byte;
            flags_left_in = FLAGS_PER_BYTE;
         end else if (is_lit) begin
            lit_in        = req_in_byte;
            cnt_in        = 5'd1;
            flag_bits_in  = {1'b0, flag_bits_ff[7:1]};
            flags_left_in = flags_left_ff - 4'd1;
         end else if (is_lo) begin
            off_lo_in = req_in_byte;
            phase_in  = 1'b1;
         end else begin
            src_in        = WIN_AW'({req_in_byte[7:4], off_lo_ff});
            cnt_in        = 5'({1'b0, req_in_byte[3:0]} + {1'b0, thr_eff} + 5'd1);
            phase_in      = 1'b0;
            flag_bits_in  = {1'b0, flag_bits_ff[7:1]};
            flags_left_in = flags_left_ff - 4'd1;
         end
      end

      if (ram_re) begin
         src_in = src_ff + WIN_AW'(1);
      end

      if (put_fire) begin
         wp_in  = wp_ff + WIN_AW'(1);
         cnt_in = cnt_ff - 5'd1;
         if (skip_ff != 32'd0) begin
            skip_in = skip_ff - 32'd1;
         end else if (emit_ff != 32'd0) begin
            emit_in      = emit_ff - 32'd1;
            rsp_valid_in = 1'b1;
            rsp_byte_in  = put_byte;
            rsp_last_in  = cnt_last || (emit_ff == 32'd1);
            rsp_done_in  = done_now;
         end
      end

      if (csr_valid) begin
         unique case (csr_index)
            CSR_LOOKAHEAD: wp_in   = start_position(csr_data[11:0]);
            CSR_THRESHOLD: thr_in  = csr_data[3:0];
            CSR_SKIP:      skip_in = csr_data;
            CSR_LIMIT:     emit_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff         <= start_position(LOOKAHEAD_DEFAULT);
         skip_ff       <= 32'd0;
         emit_ff       <= 32'd0;
         thr_ff        <= THRESHOLD_DEFAULT;
         flag_bits_ff  <= 8'd0;
         flags_left_ff <= 4'd0;
         phase_ff      <= 1'b0;
         off_lo_ff     <= 8'd0;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         wp_ff         <= wp_in;
         skip_ff       <= skip_in;
         emit_ff       <= emit_in;
         thr_ff        <= thr_in;
         flag_bits_ff  <= flag_bits_in;
         flags_left_ff <= flags_left_in;
         phase_ff      <= phase_in;
         off_lo_ff     <= off_lo_in;
         clr_ff        <= clr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      src_ff      <= src_in;
      cnt_ff      <= cnt_in;
      lit_ff      <= lit_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign status.clear_last = cmd.clear && (clr_ff == '1);
   assign status.go_lit     = take && is_lit;
   assign status.go_match   = take && phase_ff;
   assign status.put_fire   = put_fire;
   assign status.cnt_last   = cnt_last;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_stream_done = rsp_done_ff;

endmodule

@@ design/lzss_stream_decompressor.sv @@
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  req_in_byte
// rsp       out        rsp_valid / rsp_stall  rsp_out_byte, rsp_last_of_run, rsp_stream_done
// csr       in         csr_valid / csr_ready  csr_index, csr_data
//
// Flag and match offset bytes are accepted in the idle state, a literal then passes the
// literal state, and a match passes accept, a first window read, then one byte per cycle.
// The single window RAM port pair sets this: one read and one write per cycle.
// After reset a clearing pass fills the 4096-byte window with spaces;
// req_stall is high during it, csr writes are taken.
// A stalled result holds the copy loop or a literal only when its byte is to be emitted.
module lzss_stream_decompressor import lzsd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_in_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_last_of_run,
   output logic                 rsp_stream_done,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DW-1:0]    csr_data
);

   lzsd_cmd_type    cmd;
   lzsd_status_type status;

   lzsd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   lzsd_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_valid       (req_valid),
      .req_in_byte     (req_in_byte),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_stream_done (rsp_stream_done)
   );

   assign req_stall = !cmd.in_open;
   assign csr_ready = 1'b1;

endmodule

@@ design/lzsd_checker.sv @@
module lzsd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_of_run,
   input logic       rsp_stream_done
);

   // a stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_last_of_run) && $stable(rsp_stream_done))
      else $error("stalled result changed");

   // nothing follows the final result of an exhausted stream
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_stream_done && rsp_last_of_run |=> !rsp_valid)
      else $error("result after stream done");

   // window clearing blocks input right after reset
   assert property (@(posedge clock) $past(reset) |-> req_stall)
      else $error("input open during window clear");

   // no result straight out of reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind lzss_stream_decompressor lzsd_checker u_lzsd_checker (.*);
